### design/bfra_pkg.sv
// ----------------------------------------------------------------------------
// bfra_pkg
// Shared types and constants of the best-fit resource assigner.
// ----------------------------------------------------------------------------
package bfra_pkg;

    // Default table size and queue depth
    localparam int NUM_SLOTS_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Fixed field widths
    localparam int SLOT_IDX_W = 4;
    localparam int ID_W       = 8;
    localparam int CAP_W      = 10;
    localparam int DIST_W     = 14;
    localparam int HOURS_W    = 9;
    localparam int MIN_W      = 6;
    localparam int REM_W      = 6;

    // Travel time at 50 distance units per hour.
    // hours = (dist * HOURS_RECIP) >> HOURS_SHIFT is exact for 14-bit distances.
    localparam int SPEED_PER_HOUR = 50;
    localparam int HOURS_RECIP    = 20972;
    localparam int HOURS_SHIFT    = 20;
    localparam int HOURS_PROD_W   = 29;
    // minutes = (rem * 60 / 50) = (rem * MIN_RECIP) >> MIN_SHIFT for rem < 50
    localparam int MIN_RECIP      = 1230;
    localparam int MIN_SHIFT      = 10;
    localparam int MIN_PROD_W     = 16;

    // Item kinds
    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

    // Queue entry between front and back
    typedef struct packed {
        logic                  kind;
        logic [SLOT_IDX_W-1:0] slot_index;
        logic [ID_W-1:0]       unit_id;
        logic [CAP_W-1:0]      unit_capacity;
        logic                  unit_available;
        logic [ID_W-1:0]       request_id;
        logic [CAP_W-1:0]      request_demand;
        logic [DIST_W-1:0]     request_distance;
        logic [HOURS_W-1:0]    travel_hours;
    } bfra_item_t;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH,
        ST_RESULT
    } bfra_state_t;

endpackage

### design/bfra_ram.sv
// ----------------------------------------------------------------------------
// bfra_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/bfra_fifo.sv
// ----------------------------------------------------------------------------
// bfra_fifo
// Short queue that decouples the front classifier from the back sequencer.
// ----------------------------------------------------------------------------
module bfra_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

endmodule

### design/bfra_front.sv
// ----------------------------------------------------------------------------
// bfra_front
// Input side: accept transactions, drop loads outside the table and
// precompute whole travel hours before queuing the item.
// ----------------------------------------------------------------------------
module bfra_front
    import bfra_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  req_type,
    input  logic [SLOT_IDX_W-1:0] slot_index,
    input  logic [ID_W-1:0]       unit_id,
    input  logic [CAP_W-1:0]      unit_capacity,
    input  logic                  unit_available,
    input  logic [ID_W-1:0]       request_id,
    input  logic [CAP_W-1:0]      request_demand,
    input  logic [DIST_W-1:0]     request_distance,
    input  logic                  q_full,
    output logic                  q_push,
    output bfra_item_t            q_item
);

    localparam int RANGE_W = 10;

    logic                    in_range;
    logic [HOURS_PROD_W-1:0] hours_prod;

    // Loads beyond the table are accepted and dropped
    assign in_range   = (RANGE_W'(slot_index) < RANGE_W'(NUM_SLOTS));
    assign in_stall   = q_full;
    assign q_push     = in_valid && !q_full && ((req_type == KIND_REQUEST) || in_range);

    assign hours_prod = HOURS_PROD_W'(request_distance) * HOURS_PROD_W'(HOURS_RECIP);

    always_comb
    begin
        q_item.kind             = req_type;
        q_item.slot_index       = slot_index;
        q_item.unit_id          = unit_id;
        q_item.unit_capacity    = unit_capacity;
        q_item.unit_available   = unit_available;
        q_item.request_id       = request_id;
        q_item.request_demand   = request_demand;
        q_item.request_distance = request_distance;
        q_item.travel_hours     = HOURS_W'(hours_prod >> HOURS_SHIFT);
    end

endmodule

### design/bfra_back.sv
// ----------------------------------------------------------------------------
// bfra_back
// Execution side: write slots, scan the table one slot per cycle for the
// best fit, claim the winner and hold the result in the output register.
// ----------------------------------------------------------------------------
module bfra_back
    import bfra_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  bfra_item_t         q_item,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               found,
    output logic [ID_W-1:0]    assigned_id,
    output logic [ID_W-1:0]    echo_request_id,
    output logic [HOURS_W-1:0] travel_hours,
    output logic [MIN_W-1:0]   travel_minutes
);

    localparam int IDX_W   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int ENTRY_W = ID_W + CAP_W;
    localparam int MUL50_W = DIST_W + 1;

    bfra_state_t state_reg, state_next;
    logic [IDX_W-1:0]     cnt_reg, cnt_next;
    logic [NUM_SLOTS-1:0] free_reg, free_next;
    logic                 rd_vld_reg;
    logic [IDX_W-1:0]     rd_idx_reg;

    logic [CAP_W-1:0]   demand_reg;
    logic [ID_W-1:0]    req_id_reg;
    logic [HOURS_W-1:0] hours_reg;
    logic [REM_W-1:0]   rem_reg;

    logic               hit_reg;
    logic [CAP_W-1:0]   best_slack_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic [ID_W-1:0]    best_id_reg;

    logic               out_valid_reg;
    logic               found_reg;
    logic [ID_W-1:0]    assigned_id_reg;
    logic [ID_W-1:0]    echo_id_reg;
    logic [HOURS_W-1:0] hours_out_reg;
    logic [MIN_W-1:0]   minutes_out_reg;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [ID_W-1:0]    rd_id;
    logic [CAP_W-1:0]   rd_cap;
    logic [CAP_W-1:0]   rd_slack;
    logic               better;
    logic               issue;
    logic               latch;
    logic               emit;
    logic               out_free;
    logic [MUL50_W-1:0] hours_x50;
    logic [MIN_PROD_W-1:0] min_prod;

    bfra_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cnt_reg),
        .rdata (ram_rdata)
    );

    assign ram_waddr = IDX_W'(q_item.slot_index);
    assign ram_wdata = {q_item.unit_id, q_item.unit_capacity};
    assign rd_id     = ram_rdata[ENTRY_W-1:CAP_W];
    assign rd_cap    = ram_rdata[CAP_W-1:0];
    assign rd_slack  = rd_cap - demand_reg;

    // Strict compare keeps the lowest index on equal slack
    assign better = rd_vld_reg && free_reg[rd_idx_reg] && (rd_cap >= demand_reg)
                    && (!hit_reg || (rd_slack < best_slack_reg));

    assign out_free  = !out_valid_reg || !out_stall;
    assign hours_x50 = MUL50_W'(q_item.travel_hours) * MUL50_W'(SPEED_PER_HOUR);
    assign min_prod  = MIN_PROD_W'(rem_reg) * MIN_PROD_W'(MIN_RECIP);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        free_next  = free_reg;
        q_pop      = 1'b0;
        ram_we     = 1'b0;
        issue      = 1'b0;
        latch      = 1'b0;
        emit       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    if (q_item.kind == KIND_LOAD)
                    begin
                        ram_we               = 1'b1;
                        free_next[ram_waddr] = q_item.unit_available;
                    end
                    else
                    begin
                        latch      = 1'b1;
                        cnt_next   = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                issue = 1'b1;
                if (cnt_reg == IDX_W'(NUM_SLOTS - 1))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (hit_reg)
                    begin
                        free_next[best_idx_reg] = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            free_reg      <= '0;
            rd_vld_reg    <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            free_reg   <= free_next;
            rd_vld_reg <= issue;
            if (latch)
            begin
                hit_reg <= 1'b0;
            end
            else if (better)
            begin
                hit_reg <= 1'b1;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= cnt_reg;
        if (latch)
        begin
            demand_reg <= q_item.request_demand;
            req_id_reg <= q_item.request_id;
            hours_reg  <= q_item.travel_hours;
            rem_reg    <= REM_W'(q_item.request_distance - DIST_W'(hours_x50));
        end
        if (better)
        begin
            best_slack_reg <= rd_slack;
            best_idx_reg   <= rd_idx_reg;
            best_id_reg    <= rd_id;
        end
        if (emit)
        begin
            found_reg       <= hit_reg;
            echo_id_reg     <= req_id_reg;
            assigned_id_reg <= hit_reg ? best_id_reg : '0;
            hours_out_reg   <= hit_reg ? hours_reg : '0;
            minutes_out_reg <= hit_reg ? MIN_W'(min_prod >> MIN_SHIFT) : '0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign found           = found_reg;
    assign assigned_id     = assigned_id_reg;
    assign echo_request_id = echo_id_reg;
    assign travel_hours    = hours_out_reg;
    assign travel_minutes  = minutes_out_reg;

endmodule

### design/best_fit_resource_assigner_top.sv
// ----------------------------------------------------------------------------
// best_fit_resource_assigner_top
// Best-fit assignment of requests to a table of resource slots.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+---------------------------------
//  in      | input     | in_valid / in_stall | req_type, slot_index, unit_*,
//          |           |                     | request_id/demand/distance
//  out     | output    | out_valid/out_stall | found, assigned_id,
//          |           |                     | echo_request_id, travel_hours,
//          |           |                     | travel_minutes
//
//  A load transaction is executed in the idle state. A request transaction
//  latches its fields, streams the slot RAM through its single read port
//  one slot at a time, does the last compare and then claims the winner.
//  The front queues up to QUEUE_DEPTH items meanwhile.
//  Reset clears every slot's available flag; nothing is assignable until
//  loaded. A stalled result holds in the output register while the queue
//  keeps accepting.
// ----------------------------------------------------------------------------
module best_fit_resource_assigner_top
    import bfra_pkg::*;
#(
    parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  req_type,
    input  logic [SLOT_IDX_W-1:0] slot_index,
    input  logic [ID_W-1:0]       unit_id,
    input  logic [CAP_W-1:0]      unit_capacity,
    input  logic                  unit_available,
    input  logic [ID_W-1:0]       request_id,
    input  logic [CAP_W-1:0]      request_demand,
    input  logic [DIST_W-1:0]     request_distance,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  found,
    output logic [ID_W-1:0]       assigned_id,
    output logic [ID_W-1:0]       echo_request_id,
    output logic [HOURS_W-1:0]    travel_hours,
    output logic [MIN_W-1:0]      travel_minutes
);

    // Queue between the classifier and the sequencer
    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       q_empty;
    bfra_item_t q_in_item;
    bfra_item_t q_out_item;

    // Accept transactions, drop out-of-table loads, precompute hours
    bfra_front #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_front (
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .req_type         (req_type),
        .slot_index       (slot_index),
        .unit_id          (unit_id),
        .unit_capacity    (unit_capacity),
        .unit_available   (unit_available),
        .request_id       (request_id),
        .request_demand   (request_demand),
        .request_distance (request_distance),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_item           (q_in_item)
    );

    // Hold classified items until the sequencer is free
    bfra_fifo #(
        .WIDTH ($bits(bfra_item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out_item),
        .empty     (q_empty)
    );

    // Execute loads and best-fit scans, drive the result transaction
    bfra_back #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_empty         (q_empty),
        .q_item          (q_out_item),
        .q_pop           (q_pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .found           (found),
        .assigned_id     (assigned_id),
        .echo_request_id (echo_request_id),
        .travel_hours    (travel_hours),
        .travel_minutes  (travel_minutes)
    );

endmodule
